FILE: rtl/core/lz4d_pkg.sv
// Shared types and constants of the LZ4 block decompressor.
// Used by the front parser, command queue and back executor; no dependencies.
package lz4d_pkg;

  localparam int WINDOW_BYTES   = 65536;
  localparam int WIN_AW         = $clog2(WINDOW_BYTES);
  localparam int OUT_WORD_BYTES = 8;
  localparam int PACK_IW        = $clog2(OUT_WORD_BYTES);
  localparam int CMDQ_DEPTH     = 4;
  localparam int CMDQ_AW        = $clog2(CMDQ_DEPTH);

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADOF = 2'd1;
  localparam logic [1:0] ST_CAP   = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef enum logic [1:0] {
    K_NONE,
    K_LIT,
    K_MATCH
  } kind_e;

  // One parsed compressed byte, handed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  lit;
    logic [15:0] offset;
    logic [7:0]  len;
    logic        chk;      // offset just completed, check it
    logic        run_end;  // literal run ends with this byte
    logic        last;     // final compressed byte
    logic        end_tok;  // parser expects a token next
  } cmd_t;

endpackage

FILE: rtl/core/lz4d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lz4d_ram #(
  parameter int Width = 8,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/lz4d_front.sv
// Front parser: accepts compressed bytes and classifies them into commands.
// Depends on lz4d_pkg.
module lz4d_front import lz4d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [2:0] PH_TOKEN  = 3'd0;
  localparam logic [2:0] PH_LITEXT = 3'd1;
  localparam logic [2:0] PH_LIT    = 3'd2;
  localparam logic [2:0] PH_OFF0   = 3'd3;
  localparam logic [2:0] PH_OFF1   = 3'd4;
  localparam logic [2:0] PH_MEXT   = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] lrem_q, lrem_d;
  logic [3:0]  mbase_q, mbase_d;
  logic [15:0] moff_q, moff_d;
  logic        accept;
  logic [32:0] lsum;
  cmd_t        cmd;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;
  assign lsum       = {1'b0, lrem_q} + {25'd0, in_byte_i};

  // Decode one byte according to the current phase
  always_comb begin
    phase_d      = phase_q;
    lrem_d       = lrem_q;
    mbase_d      = mbase_q;
    moff_d       = moff_q;
    cmd.kind     = K_NONE;
    cmd.lit      = in_byte_i;
    cmd.offset   = moff_q;
    cmd.len      = in_byte_i;
    cmd.chk      = 1'b0;
    cmd.run_end  = 1'b0;
    cmd.last     = in_last_i;
    cmd.end_tok  = 1'b0;
    case (phase_q)
      PH_TOKEN: begin
        lrem_d  = {28'd0, in_byte_i[7:4]};
        mbase_d = in_byte_i[3:0];
        if (in_byte_i[7:4] == 4'hf) begin
          phase_d = PH_LITEXT;
        end else if (in_byte_i[7:4] != 4'h0) begin
          phase_d = PH_LIT;
        end else begin
          cmd.run_end = 1'b1;
          phase_d     = PH_OFF0;
        end
      end
      PH_LITEXT: begin
        lrem_d = lsum[32] ? 32'hffff_ffff : lsum[31:0];
        if (in_byte_i != 8'hff) begin
          phase_d = PH_LIT;
        end
      end
      PH_LIT: begin
        cmd.kind = K_LIT;
        lrem_d   = lrem_q - 32'd1;
        if (lrem_q == 32'd1) begin
          cmd.run_end = 1'b1;
          phase_d     = PH_OFF0;
        end
      end
      PH_OFF0: begin
        moff_d  = {8'd0, in_byte_i};
        phase_d = PH_OFF1;
      end
      PH_OFF1: begin
        moff_d     = {in_byte_i, moff_q[7:0]};
        cmd.kind   = K_MATCH;
        cmd.offset = {in_byte_i, moff_q[7:0]};
        cmd.chk    = 1'b1;
        if (mbase_q == 4'hf) begin
          cmd.len = 8'd19;
          phase_d = PH_MEXT;
        end else begin
          cmd.len = {4'd0, mbase_q} + 8'd4;
          phase_d = PH_TOKEN;
        end
      end
      PH_MEXT: begin
        cmd.kind = K_MATCH;
        if (in_byte_i != 8'hff) begin
          phase_d = PH_TOKEN;
        end
      end
      default: begin
        phase_d = PH_TOKEN;
      end
    endcase
    cmd.end_tok = (phase_d == PH_TOKEN);
  end

  assign cmd_o  = cmd;
  assign push_o = accept & ((cmd.kind != K_NONE) | cmd.run_end | in_last_i);

  // Advance parser state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      lrem_q  <= '0;
      mbase_q <= '0;
      moff_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      lrem_q  <= lrem_d;
      mbase_q <= mbase_d;
      moff_q  <= moff_d;
    end
  end

endmodule

FILE: rtl/core/lz4d_cmdq.sv
// Short command queue between front parser and back executor.
// Depends on lz4d_pkg.
module lz4d_cmdq import lz4d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t               ent_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, rptr_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = ent_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lz4d_back.sv
// Back executor: writes literals, copies matches from the history RAM and
// packs output words. Depends on lz4d_pkg and lz4d_ram.
module lz4d_back import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] capacity_i,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_count_o,
  output logic        out_last_o,
  output logic [1:0]  status_o,
  output logic [31:0] total_bytes_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIT   = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]  state_q, state_d;
  cmd_t        cmd_q;
  logic [7:0]  rem_q;
  logic [31:0] prod_q;
  logic        fin_q, bad_q;
  logic [63:0] pack_q;
  logic [3:0]  pcnt_q;
  logic        ov_q, olast_q;
  logic [63:0] odata_q;
  logic [3:0]  ocnt_q;
  logic [1:0]  ost_q;
  logic [31:0] otot_q;

  logic        emit_ok, emit, emit_last, app, pop, bad_off, cap_hit, fin;
  logic [1:0]  emit_st, fst;
  logic [7:0]  app_byte, rdata;
  logic        re;
  logic [WIN_AW-1:0] raddr;

  assign emit_ok = ~ov_q | ~out_stall_i;
  assign cap_hit = (prod_q >= capacity_i);
  assign bad_off = (cmd_q.offset == 16'd0) || (32'(cmd_q.offset) > prod_q)
                || (32'(cmd_q.offset) > 32'(WINDOW_BYTES));
  assign raddr   = prod_q[WIN_AW-1:0] - cmd_q.offset[WIN_AW-1:0];

  // End-of-command outcome
  always_comb begin
    fin = bad_q | cmd_q.last | (cmd_q.run_end & cap_hit);
    if (bad_q) begin
      fst = ST_BADOF;
    end else if (cmd_q.run_end) begin
      fst = cmd_q.last ? ST_OK : ST_CAP;
    end else begin
      fst = cmd_q.end_tok ? ST_OK : ST_TRUNC;
    end
  end

  // Sequence one command
  always_comb begin
    state_d   = state_q;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_st   = ST_OK;
    app       = 1'b0;
    app_byte  = cmd_q.lit;
    re        = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop = 1'b1;
          if (!fin_q) begin
            case (q_cmd_i.kind)
              K_LIT:   state_d = S_LIT;
              K_MATCH: state_d = q_cmd_i.chk ? S_CHK : S_RD;
              default: state_d = S_FLUSH;
            endcase
          end
        end
      end
      S_LIT: begin
        app     = ~cap_hit;
        state_d = S_FLUSH;
      end
      S_CHK: begin
        state_d = bad_off ? S_FLUSH : S_RD;
      end
      S_RD: begin
        if (rem_q == 8'd0 || cap_hit) begin
          state_d = S_FLUSH;
        end else if (pcnt_q == 4'(OUT_WORD_BYTES)) begin
          emit = emit_ok;
        end else begin
          re      = 1'b1;
          state_d = S_WR;
        end
      end
      S_WR: begin
        app      = 1'b1;
        app_byte = rdata;
        state_d  = S_RD;
      end
      S_FLUSH: begin
        if (pcnt_q != 4'd0 || fin) begin
          if (emit_ok) begin
            emit      = 1'b1;
            emit_last = fin;
            emit_st   = fin ? fst : ST_OK;
            state_d   = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign q_pop_o = pop;

  lz4d_ram #(
    .Width (8),
    .Depth (WINDOW_BYTES)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (app),
    .waddr_i (prod_q[WIN_AW-1:0]),
    .wdata_i (app_byte),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Hold command fields
  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= q_cmd_i;
    end
  end

  // Control, counters and packer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      prod_q  <= '0;
      fin_q   <= 1'b0;
      bad_q   <= 1'b0;
      pack_q  <= '0;
      pcnt_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        rem_q <= q_cmd_i.len;
        bad_q <= 1'b0;
      end
      if (state_q == S_CHK && bad_off) begin
        bad_q <= 1'b1;
      end
      if (app) begin
        pack_q[pcnt_q[PACK_IW-1:0]*8 +: 8] <= app_byte;
        pcnt_q <= pcnt_q + 4'd1;
        prod_q <= prod_q + 32'd1;
      end
      if (state_q == S_WR) begin
        rem_q <= rem_q - 8'd1;
      end
      if (emit) begin
        pack_q <= '0;
        pcnt_q <= '0;
        if (emit_last) begin
          fin_q <= 1'b1;
        end
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      odata_q <= pack_q;
      ocnt_q  <= pcnt_q;
      olast_q <= emit_last;
      ost_q   <= emit_st;
      otot_q  <= prod_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_data_o    = odata_q;
  assign out_count_o   = ocnt_q;
  assign out_last_o    = olast_q;
  assign status_o      = ost_q;
  assign total_bytes_o = otot_q;

endmodule

FILE: rtl/core/lz4_block_decompressor.sv
// LZ4 block decompressor top level: parser, command queue and executor.
// Depends on lz4d_pkg, lz4d_front, lz4d_cmdq and lz4d_back.
//
// Takes one compressed byte per input beat and returns decompressed bytes
// packed up to eight per output beat, first byte in the lowest bits, with
// total_bytes counting everything produced so far. The front parser takes
// a byte per cycle into a four-entry command queue unless it is full; the
// executor writes literal bytes in its literal state, copies match bytes
// via the registered read of the 64 KiB history RAM (read state, then write
// state), pausing to emit each word filled mid-match. After the final beat
// (out_last) with its status (0 ok, 1 bad offset, 2 capacity reached, 3
// truncated input), further input is absorbed without output until reset.
// Write output_capacity only while the block is idle.
module lz4_block_decompressor import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_count_o,
  output logic        out_last_o,
  output logic [1:0]  status_o,
  output logic [31:0] total_bytes_o
);

  logic [31:0] cap_q;
  logic        push, q_full, q_valid, q_pop;
  cmd_t        push_cmd, head_cmd;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 32'hffff_ffff;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lz4d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lz4d_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  lz4d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .capacity_i    (cap_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o),
    .out_count_o   (out_count_o),
    .out_last_o    (out_last_o),
    .status_o      (status_o),
    .total_bytes_o (total_bytes_o)
  );

endmodule
